>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising edge, off while reset is high
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication in the same cycle, off while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// shared constants and register codes for the quaternion vector rotator
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  // default field widths
  localparam int VEC_BITS_DEF       = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // fixed widths
  localparam int QUAT_BITS    = 16;
  localparam int OUT_BITS     = 18;
  localparam int H_BITS       = 16;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  // quaternion register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROT_W = 2'd0,
    REG_ROT_X = 2'd1,
    REG_ROT_Y = 2'd2,
    REG_ROT_Z = 2'd3
  } cfg_reg_t;

  // reset quaternion is the identity, 1.0 in Q2.14
  localparam logic signed [QUAT_BITS-1:0] ROT_W_RESET = 16'sd16384;
  localparam logic signed [QUAT_BITS-1:0] ROT_V_RESET = 16'sd0;

  // pipeline depth from accept to result strobe
  localparam int LATENCY = 6;

endpackage

`default_nettype wire

>>> src/qvr_sat.sv
// ----------------------------------------------------------------------------
// qvr_sat
// arithmetic shift of a rounded accumulator and clip to the output width
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_sat #(
  parameter int ACC_BITS = 54,
  parameter int SHIFT    = 28
) (
  input  wire logic signed [ACC_BITS-1:0]          acc,
  output logic signed [qvr_pkg::OUT_BITS-1:0]      y,
  output logic                                     clip
);

  localparam int OB = qvr_pkg::OUT_BITS;
  localparam logic signed [ACC_BITS-1:0] MAXV = ACC_BITS'(2**(OB-1) - 1);
  localparam logic signed [ACC_BITS-1:0] MINV = ACC_BITS'(-(2**(OB-1)));

  logic signed [ACC_BITS-1:0] shifted;

  always_comb begin
    shifted = acc >>> SHIFT;
    if (shifted > MAXV) begin
      y    = {1'b0, {(OB-1){1'b1}}};
      clip = 1'b1;
    end else if (shifted < MINV) begin
      y    = {1'b1, {(OB-1){1'b0}}};
      clip = 1'b1;
    end else begin
      y    = OB'(shifted);
      clip = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/quaternion_vector_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// rotates one 3-d vector per item by q * (0,v) * conj(q), q held in registers
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle and its result comes out on done,
// one result per item, in order, after passing through the six register
// stages (input, q*v products, first sums, t*q products, rounded sums,
// clip). done lasts one cycle and the receiver cannot stall, so the
// result must be captured in that cycle. busy is high only while rst is
// high. The quaternion is signed Q2.14, is used as written (not normalised),
// and must only be changed while no item is in flight; out_h is a copy of
// vec_h. Components are rounded to nearest, halves upwards, then clipped to
// 18 bits, with saturated flagging any clip.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotation #(
  parameter int VEC_BITS       = qvr_pkg::VEC_BITS_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // item input
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [VEC_BITS-1:0]             vec_x,
  input  wire logic signed [VEC_BITS-1:0]             vec_y,
  input  wire logic signed [VEC_BITS-1:0]             vec_z,
  input  wire logic signed [VEC_BITS-1:0]             vec_h,
  // quaternion register writes
  input  wire logic                                   wr_en,
  input  wire logic [qvr_pkg::CFG_IDX_BITS-1:0]       wr_index,
  input  wire logic [qvr_pkg::CFG_BITS-1:0]           wr_data,
  // result
  output logic                                        done,
  output logic signed [qvr_pkg::OUT_BITS-1:0]         out_x,
  output logic signed [qvr_pkg::OUT_BITS-1:0]         out_y,
  output logic signed [qvr_pkg::OUT_BITS-1:0]         out_z,
  output logic signed [qvr_pkg::H_BITS-1:0]           out_h,
  output logic                                        saturated
);

  localparam int QB    = qvr_pkg::QUAT_BITS;
  localparam int HB    = qvr_pkg::H_BITS;
  localparam int OB    = qvr_pkg::OUT_BITS;
  localparam int DEPTH = qvr_pkg::LATENCY;
  // q*v product, first sum, t*q product, final sum
  localparam int PW1   = QB + VEC_BITS;
  localparam int TW    = PW1 + 2;
  localparam int PW2   = TW + QB;
  localparam int SW    = PW2 + 2;
  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  // room for the rounding half as well as the sum
  localparam int FW    = ((SW > SHIFT + 1) ? SW : SHIFT + 1) + 1;
  localparam logic signed [FW-1:0] HALF = {{(FW-1){1'b0}}, 1'b1} << (SHIFT - 1);

  // quaternion registers
  logic signed [QB-1:0] rot_w, rot_x, rot_y, rot_z;
  logic signed [QB-1:0] q [4];

  // valid bits, one per stage
  logic [DEPTH-1:0] vld;

  // stage payloads
  logic signed [VEC_BITS-1:0] vin  [3];
  logic signed [PW1-1:0]      prod [4][3];
  logic signed [TW-1:0]       t    [4];
  logic signed [PW2-1:0]      mp   [3][4];
  logic signed [FW-1:0]       acc  [3];
  logic signed [HB-1:0]       h_pipe [DEPTH-1];

  logic signed [OB-1:0] sat_y [3];
  logic [2:0]           sat_clip;

  assign busy = rst;
  assign done = vld[DEPTH-1];

  // register writes; a write during reset is lost
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_w <= qvr_pkg::ROT_W_RESET;
      rot_x <= qvr_pkg::ROT_V_RESET;
      rot_y <= qvr_pkg::ROT_V_RESET;
      rot_z <= qvr_pkg::ROT_V_RESET;
    end else if (wr_en) begin
      unique case (qvr_pkg::cfg_reg_t'(wr_index))
        qvr_pkg::REG_ROT_W: rot_w <= wr_data;
        qvr_pkg::REG_ROT_X: rot_x <= wr_data;
        qvr_pkg::REG_ROT_Y: rot_y <= wr_data;
        qvr_pkg::REG_ROT_Z: rot_z <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    q[0] = rot_w;
    q[1] = rot_x;
    q[2] = rot_y;
    q[3] = rot_z;
  end

  // valid line; the pipe never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], start & ~busy};
    end
  end

  // stage 1: capture the item
  always_ff @(posedge clk) begin
    vin[0]    <= vec_x;
    vin[1]    <= vec_y;
    vin[2]    <= vec_z;
    h_pipe[0] <= HB'(vec_h);
    for (int k = 1; k < DEPTH - 1; k++) begin
      h_pipe[k] <= h_pipe[k-1];
    end
  end

  // stage 2: every quaternion part times every vector part
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] <= PW1'(q[i]) * PW1'(vin[j]);
      end
    end
  end

  // stage 3: t = q * (0, v)
  always_ff @(posedge clk) begin
    t[0] <= -TW'(prod[1][0]) - TW'(prod[2][1]) - TW'(prod[3][2]);
    t[1] <=  TW'(prod[0][0]) + TW'(prod[2][2]) - TW'(prod[3][1]);
    t[2] <=  TW'(prod[0][1]) - TW'(prod[1][2]) + TW'(prod[3][0]);
    t[3] <=  TW'(prod[0][2]) + TW'(prod[1][1]) - TW'(prod[2][0]);
  end

  // stage 4: products of t with conj(q), indexed by component then t term
  always_ff @(posedge clk) begin
    mp[0][0] <= PW2'(t[0]) * PW2'(q[1]);
    mp[0][1] <= PW2'(t[1]) * PW2'(q[0]);
    mp[0][2] <= PW2'(t[2]) * PW2'(q[3]);
    mp[0][3] <= PW2'(t[3]) * PW2'(q[2]);
    mp[1][0] <= PW2'(t[0]) * PW2'(q[2]);
    mp[1][1] <= PW2'(t[1]) * PW2'(q[3]);
    mp[1][2] <= PW2'(t[2]) * PW2'(q[0]);
    mp[1][3] <= PW2'(t[3]) * PW2'(q[1]);
    mp[2][0] <= PW2'(t[0]) * PW2'(q[3]);
    mp[2][1] <= PW2'(t[1]) * PW2'(q[2]);
    mp[2][2] <= PW2'(t[2]) * PW2'(q[1]);
    mp[2][3] <= PW2'(t[3]) * PW2'(q[0]);
  end

  // stage 5: vector part of t * conj(q), plus half an lsb for rounding
  always_ff @(posedge clk) begin
    acc[0] <= HALF - FW'(mp[0][0]) + FW'(mp[0][1]) - FW'(mp[0][2]) + FW'(mp[0][3]);
    acc[1] <= HALF - FW'(mp[1][0]) + FW'(mp[1][1]) + FW'(mp[1][2]) - FW'(mp[1][3]);
    acc[2] <= HALF - FW'(mp[2][0]) - FW'(mp[2][1]) + FW'(mp[2][2]) + FW'(mp[2][3]);
  end

  // stage 6: drop the fraction and clip
  for (genvar c = 0; c < 3; c++) begin : g_sat
    qvr_sat #(
      .ACC_BITS (FW),
      .SHIFT    (SHIFT)
    ) u_sat (
      .acc  (acc[c]),
      .y    (sat_y[c]),
      .clip (sat_clip[c])
    );
  end

  always_ff @(posedge clk) begin
    out_x     <= sat_y[0];
    out_y     <= sat_y[1];
    out_z     <= sat_y[2];
    out_h     <= h_pipe[DEPTH-2];
    saturated <= |sat_clip;
  end

endmodule

`default_nettype wire

>>> src/qvr_checker.sv
// ----------------------------------------------------------------------------
// qvr_checker
// port-level checks on the quaternion vector rotator
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qvr_checker #(
  parameter int VEC_BITS = qvr_pkg::VEC_BITS_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic signed [VEC_BITS-1:0]         vec_h,
  input wire logic                               done,
  input wire logic signed [qvr_pkg::OUT_BITS-1:0] out_x,
  input wire logic signed [qvr_pkg::OUT_BITS-1:0] out_y,
  input wire logic signed [qvr_pkg::OUT_BITS-1:0] out_z,
  input wire logic signed [qvr_pkg::H_BITS-1:0]   out_h,
  input wire logic                               saturated
);

  localparam int OB  = qvr_pkg::OUT_BITS;
  localparam int HB  = qvr_pkg::H_BITS;
  localparam int LAT = qvr_pkg::LATENCY;
  localparam logic signed [OB-1:0] OMAX = {1'b0, {(OB-1){1'b1}}};
  localparam logic signed [OB-1:0] OMIN = {1'b1, {(OB-1){1'b0}}};

  logic accepted;
  logic signed [HB-1:0] h_in;
  logic any_rail;

  assign accepted = start & ~busy;
  assign h_in     = HB'(vec_h);
  assign any_rail = (out_x == OMAX) || (out_x == OMIN) || (out_y == OMAX) ||
                    (out_y == OMIN) || (out_z == OMAX) || (out_z == OMIN);

  // exactly one result per item, each delayed by the package pipeline depth
  `ASSERT_HOLDS(a_one_result, clk, rst, done == $past(accepted, LAT), "result strobe out of step with accepted items")

  // the fourth component belongs to the same item as the strobe
  `ASSERT_IMPLIES(a_h_follows, clk, rst, done, out_h == $past(h_in, LAT), "out_h does not match its item")

  // a clip always leaves some component on a rail
  `ASSERT_IMPLIES(a_sat_rail, clk, rst, done && saturated, any_rail, "saturated without a clipped component")

endmodule

bind quaternion_vector_rotation qvr_checker #(
  .VEC_BITS (VEC_BITS)
) u_qvr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .vec_h     (vec_h),
  .done      (done),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .out_h     (out_h),
  .saturated (saturated)
);

`default_nettype wire

>>> test/qvr_rotation_checker.sv
// ----------------------------------------------------------------------------
// qvr_rotation_checker
// watches the item, register and result channels of the quaternion rotator,
// predicts every rotated vector and compares it with what comes out
// ----------------------------------------------------------------------------

module qvr_rotation_checker (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic                                        busy,
  input  logic signed [qvr_pkg::VEC_BITS_DEF-1:0]     vec_x,
  input  logic signed [qvr_pkg::VEC_BITS_DEF-1:0]     vec_y,
  input  logic signed [qvr_pkg::VEC_BITS_DEF-1:0]     vec_z,
  input  logic signed [qvr_pkg::VEC_BITS_DEF-1:0]     vec_h,
  input  logic                                        wr_en,
  input  logic [qvr_pkg::CFG_IDX_BITS-1:0]            wr_index,
  input  logic [qvr_pkg::CFG_BITS-1:0]                wr_data,
  input  logic                                        done,
  input  logic signed [qvr_pkg::OUT_BITS-1:0]         out_x,
  input  logic signed [qvr_pkg::OUT_BITS-1:0]         out_y,
  input  logic signed [qvr_pkg::OUT_BITS-1:0]         out_z,
  input  logic signed [qvr_pkg::H_BITS-1:0]           out_h,
  input  logic                                        saturated,
  output int                                          fail_count,
  output int                                          pending,
  output int                                          results_checked,
  output int                                          clipped_results
);

  import qvr_pkg::*;

  localparam int     ROUND_SHIFT = 2 * QUAT_FRAC_BITS_DEF;
  localparam longint ROUND_HALF  = longint'(1) << (ROUND_SHIFT - 1);
  localparam longint CLIP_HIGH   = (longint'(1) << (OUT_BITS - 1)) - 1;
  localparam longint CLIP_LOW    = -(longint'(1) << (OUT_BITS - 1));

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic signed [OUT_BITS-1:0] z;
    logic signed [H_BITS-1:0]   h;
    logic                       sat;
  } rotated_t;

  logic signed [QUAT_BITS-1:0] quat_w, quat_x, quat_y, quat_z;
  rotated_t                    rotated_q[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    clipped_results = 0;
  end

  // q * (0,v) * conj(q), exact in 64 bits, then round and clip
  function automatic rotated_t rotate_vector(logic signed [VEC_BITS_DEF-1:0] vx, vy, vz, vh);
    longint                     w, x, y, z, px, py, pz, t0, t1, t2, t3, r;
    longint                     acc[3];
    logic signed [OUT_BITS-1:0] comp[3];
    rotated_t                   res;
    w  = quat_w;
    x  = quat_x;
    y  = quat_y;
    z  = quat_z;
    px = vx;
    py = vy;
    pz = vz;
    t0 = -x * px - y * py - z * pz;
    t1 =  w * px + y * pz - z * py;
    t2 =  w * py - x * pz + z * px;
    t3 =  w * pz + x * py - y * px;
    acc[0] = -t0 * x + t1 * w - t2 * z + t3 * y;
    acc[1] = -t0 * y + t1 * z + t2 * w - t3 * x;
    acc[2] = -t0 * z - t1 * y + t2 * x + t3 * w;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // halves go upwards
      r = (acc[i] + ROUND_HALF) >>> ROUND_SHIFT;
      if (r > CLIP_HIGH) begin
        comp[i] = CLIP_HIGH[OUT_BITS-1:0];
        res.sat = 1'b1;
      end else if (r < CLIP_LOW) begin
        comp[i] = CLIP_LOW[OUT_BITS-1:0];
        res.sat = 1'b1;
      end else begin
        comp[i] = r[OUT_BITS-1:0];
      end
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.h = vh;
    return res;
  endfunction

  always @(posedge clk) begin
    rotated_t want;
    if (rst) begin
      quat_w <= ROT_W_RESET;
      quat_x <= ROT_V_RESET;
      quat_y <= ROT_V_RESET;
      quat_z <= ROT_V_RESET;
      rotated_q.delete();
    end else begin
      // results first, so an item taken at this edge is never matched here
      if (done) begin
        if (rotated_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result with no item in flight: x=%0d y=%0d z=%0d h=%0d sat=%0b",
                     out_x, out_y, out_z, out_h, saturated);
        end else begin
          want = rotated_q.pop_front();
          results_checked++;
          if (saturated) clipped_results++;
          if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
              out_h !== want.h || saturated !== want.sat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch on result %0d: want x=%0d y=%0d z=%0d h=%0d sat=%0b, %s",
                       results_checked, want.x, want.y, want.z, want.h, want.sat,
                       $sformatf("got x=%0d y=%0d z=%0d h=%0d sat=%0b",
                                 out_x, out_y, out_z, out_h, saturated));
          end
        end
      end
      // prediction uses the quaternion held before any write at this edge
      if (start && !busy)
        rotated_q.push_back(rotate_vector(vec_x, vec_y, vec_z, vec_h));
      if (wr_en) begin
        case (cfg_reg_t'(wr_index))
          REG_ROT_W: quat_w <= wr_data;
          REG_ROT_X: quat_x <= wr_data;
          REG_ROT_Y: quat_y <= wr_data;
          REG_ROT_Z: quat_z <= wr_data;
          default: ;
        endcase
      end
    end
    pending <= rotated_q.size();
  end

endmodule

>>> test/quaternion_vector_rotation_tb.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_tb
// drives vectors and quaternion writes into the rotator and gives a verdict;
// prediction and comparison live in the checker beside the block
// ----------------------------------------------------------------------------

module quaternion_vector_rotation_tb;

  import qvr_pkg::*;

  // cycles with nothing taken or returned before the run is called hung
  localparam int STALL_LIMIT   = 200;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS   = 150;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic signed [VEC_BITS_DEF-1:0] vec_x, vec_y, vec_z, vec_h;
  logic                        wr_en;
  cfg_reg_t                    wr_index;
  logic [CFG_BITS-1:0]         wr_data;
  logic                        done;
  logic signed [OUT_BITS-1:0]  out_x, out_y, out_z;
  logic signed [H_BITS-1:0]    out_h;
  logic                        saturated;

  int fail_count, pending, results_checked, clipped_results;
  int items_sent;
  int settings_loaded;
  int stall_cycles;
  bit gaps_on;

  quaternion_vector_rotation u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .vec_h     (vec_h),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_h     (out_h),
    .saturated (saturated)
  );

  qvr_rotation_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .vec_x           (vec_x),
    .vec_y           (vec_y),
    .vec_z           (vec_z),
    .vec_h           (vec_h),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .done            (done),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_h           (out_h),
    .saturated       (saturated),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .clipped_results (clipped_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hang guard: any accepted item or returned result clears the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d items in flight", stall_cycles, pending);
      $display("quaternion_vector_rotation_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one item; an idle burst may go in front of it
  task automatic send_vector(input logic [15:0] vx, vy, vz, vh);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    vec_x <= vx;
    vec_y <= vy;
    vec_z <= vz;
    vec_h <= vh;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // let every item drain, then write all four quaternion registers
  task automatic load_quaternion(input logic [15:0] qw, qx, qy, qz);
    start <= 1'b0;
    // wait for a clock edge so the last item taken shows up in the pending count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_ROT_W;
    wr_data  <= qw;
    @(posedge clk);
    wr_index <= REG_ROT_X;
    wr_data  <= qx;
    @(posedge clk);
    wr_index <= REG_ROT_Y;
    wr_data  <= qy;
    @(posedge clk);
    wr_index <= REG_ROT_Z;
    wr_data  <= qz;
    @(posedge clk);
    wr_en    <= 1'b0;
    settings_loaded++;
  endtask

  // one random component: mostly full range, some edge values, some small
  function automatic logic [15:0] pick_component(input int mode);
    logic [15:0] edge_vals[7];
    edge_vals = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF};
    case (mode)
      0:       return edge_vals[$urandom_range(0, 6)];
      1:       return 16'($signed($urandom_range(0, 127)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int qmode;
    logic [15:0] qv[4];
    rst        <= 1'b1;
    start      <= 1'b0;
    vec_x      <= '0;
    vec_y      <= '0;
    vec_z      <= '0;
    vec_h      <= '0;
    wr_en      <= 1'b0;
    wr_index   <= REG_ROT_W;
    wr_data    <= '0;
    items_sent      = 0;
    settings_loaded = 0;
    stall_cycles    = 0;
    gaps_on         = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset quaternion is the identity: vector comes back as it went in
    send_vector(16'h7FFF, 16'h8000, 16'h0000, 16'h8000);
    send_vector(16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF);
    send_vector(16'h0001, 16'hFFFF, 16'h7FFF, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_vector(16'h3039, 16'hA460, 16'h0007, 16'h5A5A);

    // half scale: |q|^2 = 1/4, so +-2 and +-6 land on exact halves
    load_quaternion(16'd8192, 16'd0, 16'd0, 16'd0);
    send_vector(16'd2, -16'sd2, 16'd6, 16'hA5A5);
    send_vector(-16'sd6, -16'sd1, 16'd1, 16'h0001);
    send_vector(16'h7FFF, 16'h8000, -16'sd6, 16'h8001);

    // far from unit length at both ends: clipping
    load_quaternion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1234);
    send_vector(16'h8000, 16'h8000, 16'h8000, 16'hEDCB);
    send_vector(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    load_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vector(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_vector(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    send_vector(16'h0000, 16'h0001, 16'h0000, 16'h0001);
    send_vector(16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // quarter turn about z, then a third of a turn about the diagonal
    load_quaternion(16'd11585, 16'd0, 16'd0, 16'd11585);
    send_vector(16'h7FFF, 16'h0000, 16'h0000, 16'h0F0F);
    send_vector(16'h8000, 16'h7FFF, 16'h8000, 16'hF0F0);
    send_vector(16'd100, -16'sd200, 16'd300, 16'h00FF);
    load_quaternion(16'd8192, 16'd8192, 16'd8192, 16'd8192);
    send_vector(16'h7FFF, 16'h8000, 16'h0001, 16'hFF00);
    send_vector(16'd1000, 16'd2000, 16'd3000, 16'h3C3C);

    // random part: a fresh quaternion per phase, no idling at the end
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      qmode = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
        case (qmode)
          0: qv[k] = 16'($urandom);
          1: qv[k] = 16'($signed($urandom_range(0, 16384)) - 8192);
          2: qv[k] = pick_component(0);
          default: qv[k] = (k == 0) ? 16'd16384 : pick_component(1);
        endcase
      end
      if (phase == RANDOM_PHASES - 1)
        qv = '{16'd16384, 16'd0, 16'd0, 16'd0};
      load_quaternion(qv[0], qv[1], qv[2], qv[3]);
      gaps_on = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_vector(pick_component($urandom_range(0, 7)),
                    pick_component($urandom_range(0, 7)),
                    pick_component($urandom_range(0, 7)),
                    16'($urandom));
    end

    // drain, then give any stray strobe a chance to show up
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);

    $display("sent %0d vectors under %0d quaternion settings, identity and extremes included",
             items_sent, settings_loaded);
    $display("checked %0d rotated results, %0d of them clipped", results_checked,
             clipped_results);
    if (fail_count == 0) begin
      $display("quaternion_vector_rotation_tb: done, clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("quaternion_vector_rotation_tb: done, errors");
    end
    $finish;
  end

endmodule
